>>> sv/dfd_pkg.sv
package dfd_pkg;

    // field widths
    localparam int FIELD_W     = 32;
    localparam int QUOT_W      = 62;
    localparam int DIGITS_W    = 4;
    localparam int POW_W       = 30;
    localparam int OPERAND_DEF = 32;

    localparam logic [DIGITS_W-1:0] DIGITS_MAX   = 4'd9;
    localparam logic [DIGITS_W-1:0] DIGITS_RESET = 4'd8;

    typedef struct packed {
        logic signed [FIELD_W-1:0] numerator;
        logic signed [FIELD_W-1:0] denominator;
    } t_dfd_in;

    typedef struct packed {
        logic signed [QUOT_W-1:0] scaled_quotient;
        logic                     divide_by_zero;
    } t_dfd_out;

    // broadcast controls for the remainder cells
    typedef struct packed {
        logic load;
        logic step;
        logic take;
    } t_dfd_cell_ctl;

    // ten to the digit count, counts above nine saturate
    function automatic logic [POW_W-1:0] pow_ten(input logic [DIGITS_W-1:0] d);
        logic [POW_W-1:0] p;
        case (d) inside
            4'd0:                p = 30'd1;
            4'd1:                p = 30'd10;
            4'd2:                p = 30'd100;
            4'd3:                p = 30'd1000;
            4'd4:                p = 30'd10000;
            4'd5:                p = 30'd100000;
            4'd6:                p = 30'd1000000;
            4'd7:                p = 30'd10000000;
            4'd8:                p = 30'd100000000;
            [DIGITS_MAX:4'd15]:  p = 30'd1000000000;
            default:             p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

>>> sv/decimal_fraction_divider.sv
// decimal fraction divider: sign * floor(|a| * 10^d / |b|), d from the digits register
// (saturated at nine); an accepted start moves the sequencer to the multiply state, then to
// the divide state, one quotient bit per cycle through the row of remainder cells, then to
// the sign state, which registers the signed result and sets the result strobe; a new start is taken only in idle
// reset: synchronous active low, sequencer idle, strobe low, digits register back to eight
// the receiver cannot stall: o_valid is high for exactly one cycle per result
module decimal_fraction_divider #(
    parameter int OPERAND_WIDTH = dfd_pkg::OPERAND_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dfd_pkg::t_dfd_in                    i_in,
    input  logic                                i_cfg_we,
    input  logic [dfd_pkg::DIGITS_W-1:0]        i_cfg_wdata,
    output logic                                o_valid,
    output dfd_pkg::t_dfd_out                   o_out
);

    localparam int W     = OPERAND_WIDTH;
    // scaled dividend width: |a| <= 2^(W-1), 10^9 < 2^30
    localparam int PW    = W + dfd_pkg::POW_W;
    localparam int CNT_W = $clog2(PW);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [dfd_pkg::DIGITS_W-1:0] r_digits;
    logic [CNT_W-1:0]             r_cnt;
    logic [W-1:0]                 r_a_mag;
    logic                         r_neg;
    logic                         r_zero;
    // dividend bits shift out at the top, quotient bits shift in at the bottom
    logic [PW-1:0]                r_quo;
    logic                         r_valid;
    dfd_pkg::t_dfd_out            r_out;

    logic                         w_accept;
    logic [W-1:0]                 w_a_raw;
    logic [W-1:0]                 w_b_raw;
    logic [W-1:0]                 w_a_mag;
    logic [W-1:0]                 w_b_mag;
    logic                         w_a_pos;
    logic                         w_b_pos;
    logic [PW-1:0]                w_product;
    logic [dfd_pkg::QUOT_W-1:0]   w_q_ext;
    dfd_pkg::t_dfd_cell_ctl       w_ctl;
    logic [W-1:0]                 w_rem;
    logic [W:0]                   w_borrow;
    logic [W-1:0]                 w_shift;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // operand magnitudes from the low operand bits, most negative maps to 2^(W-1)
    assign w_a_raw = i_in.numerator[W-1:0];
    assign w_b_raw = i_in.denominator[W-1:0];
    assign w_a_mag = w_a_raw[W-1] ? (~w_a_raw + 1'b1) : w_a_raw;
    assign w_b_mag = w_b_raw[W-1] ? (~w_b_raw + 1'b1) : w_b_raw;
    assign w_a_pos = !w_a_raw[W-1] && (w_a_raw != '0);
    assign w_b_pos = !w_b_raw[W-1] && (w_b_raw != '0);

    // single multiply by the power-of-ten constant
    assign w_product = PW'(r_a_mag) * PW'(dfd_pkg::pow_ten(r_digits));

    // row of remainder cells, each cell loads its divisor bit at accept
    assign w_ctl.load = w_accept;
    assign w_ctl.step = (r_state == S_DIV);
    assign w_ctl.take = ~w_borrow[W];   // no borrow out of the top: remainder >= divisor

    assign w_borrow[0] = 1'b0;
    assign w_shift[0]  = r_quo[PW-1];

    genvar gi;
    generate
        for (gi = 0; gi < W; gi++) begin : g_cell
            if (gi > 0) begin : g_link
                assign w_shift[gi] = w_rem[gi-1];
            end
            dfd_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_div_bit (w_b_mag[gi]),
                .i_shift   (w_shift[gi]),
                .i_borrow  (w_borrow[gi]),
                .o_rem     (w_rem[gi]),
                .o_borrow  (w_borrow[gi+1])
            );
        end
    endgenerate

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(PW - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_digits <= dfd_pkg::DIGITS_RESET;
            r_valid  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (i_cfg_we) r_digits <= i_cfg_wdata;
            if (r_state == S_MUL) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload path
    assign w_q_ext = dfd_pkg::QUOT_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_mag <= w_a_mag;
            r_neg   <= (w_a_pos != w_b_pos);
            r_zero  <= (w_b_mag == '0);
        end
        if (r_state == S_MUL) begin
            r_quo <= w_product;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[PW-2:0], w_ctl.take};
        end
        if (r_state == S_OUT) begin
            r_out.divide_by_zero <= r_zero;
            if (r_zero) begin
                r_out.scaled_quotient <= '0;
            end else if (r_neg) begin
                r_out.scaled_quotient <= -w_q_ext;
            end else begin
                r_out.scaled_quotient <= w_q_ext;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

>>> sv/dfd_cell.sv
module dfd_cell (
    input  logic                   i_clk,
    input  dfd_pkg::t_dfd_cell_ctl i_ctl,
    input  logic                   i_div_bit,
    input  logic                   i_shift,
    input  logic                   i_borrow,
    output logic                   o_rem,
    output logic                   o_borrow
);

    logic r_rem;
    logic r_div;
    logic w_diff;

    // one bit of the trial subtract: shifted remainder minus divisor
    assign w_diff   = i_shift ^ r_div ^ i_borrow;
    assign o_borrow = (~i_shift & r_div) | (~i_shift & i_borrow) | (r_div & i_borrow);
    assign o_rem    = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= 1'b0;
            r_div <= i_div_bit;
        end else if (i_ctl.step) begin
            r_rem <= i_ctl.take ? w_diff : i_shift;
        end
    end

endmodule
